>>> src/phrd_pkg.sv
package phrd_pkg;

  localparam logic signed [31:0] QAlpha   = 32'sd265053169;
  localparam logic signed [31:0] QB0      = 32'sd972187;
  localparam logic signed [31:0] QB1      = 32'sd1944375;
  localparam logic signed [31:0] QB2      = 32'sd972187;
  localparam logic signed [31:0] QNegA1   = 32'sd489275945;
  localparam logic signed [31:0] QNegA2   = -32'sd224729238;
  localparam logic signed [31:0] QDecay   = 32'sd65208;
  localparam logic signed [31:0] QLowFrac = 32'sd19661;
  localparam logic [16:0] BpmNum = 17'd60000;

  localparam logic signed [63:0] RoundHalf = 64'sd134217728;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] mx;
    logic signed [63:0] mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    if (v > mx) begin
      sat32 = 32'sh7fffffff;
    end else if (v < mn) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

>>> src/ppg_heart_rate_detector.sv
// channel  | valid           | stall           | payload
// in       | in_valid_i      | in_stall_o      | adc_sample_i, time_ms_i
// out      | out_valid_o     | out_stall_i     | filtered_sample_o, beat_found_o,
//          |                 |                 | beat_interval_ms_o, beats_per_minute_o
// cfg      | cfg_we_i        | -               | refractory_ms_i
// a sample is processed on one shared 32x32 multiplier; the next sample is accepted only
//   after the sequencer has registered its result and returned to idle
// a beat after the first adds a compare-swap sort (depth five) for the median and
//   a restoring divide, which is skipped when the median is zero
// reset clears all filter, envelope and history state; refractory_ms reads 300
// a finished result sits in the output register; the next sample is accepted
//   while it waits, and the sequencer stalls only if a second result is ready
module ppg_heart_rate_detector #(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [11:0] adc_sample_i,
  input  logic        [31:0] time_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] filtered_sample_o,
  output logic               beat_found_o,
  output logic        [15:0] beat_interval_ms_o,
  output logic        [15:0] beats_per_minute_o,
  input  logic               cfg_we_i,
  input  logic        [15:0] refractory_ms_i
);

  localparam int SlotW = $clog2(HISTORY_DEPTH);
  localparam int MidIdx = HISTORY_DEPTH / 2;

  typedef enum logic [4:0] {
    S_IDLE, S_HP, S_HPW, S_W0, S_W1, S_W2, S_WS, S_L0, S_L1, S_L2, S_LS,
    S_ENV, S_ENVW, S_LOW, S_DET, S_SORT, S_DIV, S_DONE
  } state_e;

  state_e state_q;

  logic        [11:0] adc_q, hp_in_q;
  logic        [31:0] time_q;
  logic signed [31:0] hp_out_q, d0_q, d1_q, w_q;
  logic signed [63:0] lp_q;
  logic        [31:0] env_q, thr_q;
  logic               above_q, seen_q;
  logic        [31:0] last_beat_q;
  logic        [15:0] hist_q [HISTORY_DEPTH];
  logic        [15:0] sort_q [HISTORY_DEPTH];
  logic   [SlotW-1:0] slot_q;
  logic        [15:0] interval_q, bpm_q, refr_q;
  logic        [15:0] sidx_q;
  logic        [16:0] rem_q;
  logic        [15:0] quo_q;
  logic         [4:0] dcnt_q;
  logic               beat_q;

  // shared multiply-accumulate
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_q, acc_q;

  logic               out_valid_q;
  logic signed [15:0] out_filt_q;
  logic               out_beat_q;
  logic        [15:0] out_int_q, out_bpm_q;

  logic signed [31:0] dadc;
  logic signed [63:0] rnd, filt64;
  logic        [63:0] mag;
  logic        [31:0] since;
  logic        [31:0] low_val;
  logic        [SlotW-1:0] spos;

  assign since = time_q - last_beat_q;
  assign rnd = acc_q + phrd_pkg::RoundHalf;
  assign mag = lp_q[63] ? 64'(-lp_q) : 64'(lp_q);
  assign spos = sidx_q[SlotW-1:0];
  assign low_val = prod_q[47:16];
  assign dadc = 32'($signed({1'b0, adc_q})) - 32'($signed({1'b0, hp_in_q}));

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_HP:  begin ma = phrd_pkg::QAlpha;   mb = hp_out_q; end
      S_HPW: begin ma = phrd_pkg::QAlpha;   mb = dadc; end
      S_W0:  begin ma = phrd_pkg::QNegA1;   mb = d0_q; end
      S_W1:  begin ma = phrd_pkg::QNegA2;   mb = d1_q; end
      S_L0:  begin ma = phrd_pkg::QB0;      mb = w_q;  end
      S_L1:  begin ma = phrd_pkg::QB1;      mb = d0_q; end
      S_L2:  begin ma = phrd_pkg::QB2;      mb = d1_q; end
      S_ENV: begin ma = phrd_pkg::QDecay;   mb = $signed(env_q); end
      S_LOW: begin ma = phrd_pkg::QLowFrac; mb = $signed({1'b0, env_q[31:1]}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign filt64 = lp_q / 64'sd4096;

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      refr_q <= 16'd300;
      adc_q <= '0;
      time_q <= '0;
      hp_in_q <= '0;
      hp_out_q <= '0;
      d0_q <= '0;
      d1_q <= '0;
      w_q <= '0;
      lp_q <= '0;
      env_q <= '0;
      thr_q <= '0;
      above_q <= 1'b0;
      seen_q <= 1'b0;
      last_beat_q <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) sort_q[i] <= '0;
      slot_q <= '0;
      interval_q <= '0;
      bpm_q <= '0;
      sidx_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      dcnt_q <= '0;
      beat_q <= 1'b0;
      prod_q <= '0;
      acc_q <= '0;
      out_valid_q <= 1'b0;
      out_filt_q <= '0;
      out_beat_q <= 1'b0;
      out_int_q <= '0;
      out_bpm_q <= '0;
    end else begin
      if (cfg_we_i) refr_q <= refractory_ms_i;
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;
      prod_q <= ma * mb;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            adc_q <= adc_sample_i;
            time_q <= time_ms_i;
            state_q <= S_HP;
          end
        end
        S_HP: begin
          state_q <= S_HPW;
        end
        S_HPW: begin
          acc_q <= prod_q;
          state_q <= S_W0;
        end
        S_W0: begin
          acc_q <= acc_q + (prod_q <<< 12);
          state_q <= S_W1;
        end
        S_W1: begin
          hp_in_q <= adc_q;
          hp_out_q <= phrd_pkg::sat32(rnd >>> 28);
          acc_q <= prod_q;
          state_q <= S_W2;
        end
        S_W2: begin
          acc_q <= acc_q + prod_q + (64'(hp_out_q) <<< 28);
          state_q <= S_WS;
        end
        S_WS: begin
          w_q <= phrd_pkg::sat32(rnd >>> 28);
          state_q <= S_L0;
        end
        S_L0: begin
          state_q <= S_L1;
        end
        S_L1: begin
          acc_q <= prod_q;
          state_q <= S_L2;
        end
        S_L2: begin
          acc_q <= acc_q + prod_q;
          state_q <= S_LS;
        end
        S_LS: begin
          acc_q <= acc_q + prod_q;
          state_q <= S_ENV;
        end
        S_ENV: begin
          lp_q <= rnd >>> 28;
          d1_q <= d0_q;
          d0_q <= w_q;
          state_q <= S_ENVW;
        end
        S_ENVW: begin
          if (mag > 64'(env_q)) begin
            env_q <= (mag > 64'hffffffff) ? 32'hffffffff : mag[31:0];
          end else begin
            env_q <= prod_q[47:16];
          end
          state_q <= S_LOW;
        end
        S_LOW: begin
          thr_q <= env_q >> 1;
          state_q <= S_DET;
        end
        S_DET: begin
          if (lp_q > $signed(64'(thr_q)) && !above_q && (!seen_q || since > 32'(refr_q))) begin
            above_q <= 1'b1;
            beat_q <= 1'b1;
            seen_q <= 1'b1;
            last_beat_q <= time_q;
            if (seen_q) begin
              interval_q <= since[15:0];
              for (int i = 0; i < HISTORY_DEPTH; i++) begin
                sort_q[i] <= (i == int'(slot_q)) ? since[15:0] : hist_q[i];
              end
              hist_q[slot_q] <= since[15:0];
              slot_q <= (int'(slot_q) == HISTORY_DEPTH - 1) ? '0 : slot_q + 1'b1;
              sidx_q <= '0;
              state_q <= S_SORT;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            beat_q <= 1'b0;
            state_q <= S_DONE;
            if (lp_q < $signed(64'(low_val))) above_q <= 1'b0;
          end
        end
        S_SORT: begin
          // one compare-swap per cycle, bubble passes until the median is placed
          if (sort_q[spos] > sort_q[spos + 1'b1]) begin
            sort_q[spos] <= sort_q[spos + 1'b1];
            sort_q[spos + 1'b1] <= sort_q[spos];
          end
          if (int'(sidx_q) >= HISTORY_DEPTH * (HISTORY_DEPTH - 1) - 1) begin
            rem_q <= '0;
            quo_q <= '0;
            dcnt_q <= '0;
            state_q <= S_DIV;
          end
          sidx_q <= (int'(spos) == HISTORY_DEPTH - 2) ?
                    ((sidx_q & ~16'(2**SlotW - 1)) + 16'(2**SlotW)) : sidx_q + 1'b1;
        end
        S_DIV: begin
          // restoring divide of 60000 by the median, one bit per cycle
          if (sort_q[MidIdx] == '0) begin
            state_q <= S_DONE;
          end else begin
            dcnt_q <= dcnt_q + 1'b1;
            if (dcnt_q == 5'd16) begin
              bpm_q <= quo_q;
              state_q <= S_DONE;
            end else begin
              if (({rem_q[15:0], phrd_pkg::BpmNum[15 - dcnt_q[3:0]]}) >= 17'(sort_q[MidIdx])) begin
                rem_q <= {rem_q[15:0], phrd_pkg::BpmNum[15 - dcnt_q[3:0]]} - 17'(sort_q[MidIdx]);
                quo_q <= {quo_q[14:0], 1'b1};
              end else begin
                rem_q <= {rem_q[15:0], phrd_pkg::BpmNum[15 - dcnt_q[3:0]]};
                quo_q <= {quo_q[14:0], 1'b0};
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_filt_q <= (filt64 > 64'sd32767) ? 16'sh7fff :
                          (filt64 < -64'sd32768) ? 16'sh8000 : filt64[15:0];
            out_beat_q <= beat_q;
            out_int_q <= interval_q;
            out_bpm_q <= bpm_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_sample_o = out_filt_q;
  assign beat_found_o = out_beat_q;
  assign beat_interval_ms_o = out_int_q;
  assign beats_per_minute_o = out_bpm_q;

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accepting while busy");
  a_beat_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_beat_q && $rose(out_valid_q)) |-> above_q)
    else $error("beat without arming");
  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(seen_q) |-> seen_q) else $error("beat_seen cleared");
`endif

endmodule
